FILE: hdl/twbl_pkg.sv
package twbl_pkg;

  // Fixed field widths of the words on the two channels
  localparam int OP_W         = 2;
  localparam int CHANNEL_W    = 8;
  localparam int BIN_INDEX_W  = 5;
  localparam int BIN_COUNT_W  = 6;
  localparam int EDGE_W       = 16;
  localparam int CORR_W       = 16;
  localparam int ENERGY_W     = 16;
  localparam int BIN_FOUND_W  = 5;

  // Defaults for the top level parameters
  localparam int NUM_CHANNELS_DEF = 256;
  localparam int MAX_BINS_DEF     = 32;
  localparam int ENERGY_BITS_DEF  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_BIN = 2'd0,
    OP_SET_COUNT = 2'd1,
    OP_QUERY     = 2'd2
  } op_t;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_TABLE = 1'b1;

endpackage

FILE: hdl/twbl_if.sv
interface twbl_in_if;
  import twbl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               op;
  logic [CHANNEL_W-1:0]          channel;
  logic [BIN_INDEX_W-1:0]        bin_index;
  logic [BIN_COUNT_W-1:0]        bin_count;
  logic [EDGE_W-1:0]             edge_value;
  logic signed [CORR_W-1:0]      correction_value;
  logic [ENERGY_W-1:0]           energy;

  modport source (
    output valid, op, channel, bin_index, bin_count, edge_value, correction_value, energy,
    input  ready
  );
  modport sink (
    input  valid, op, channel, bin_index, bin_count, edge_value, correction_value, energy,
    output ready
  );
endinterface

interface twbl_out_if;
  import twbl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [CORR_W-1:0]      correction;
  logic [BIN_FOUND_W-1:0]        bin_found;
  logic                          status;

  modport source (
    output valid, correction, bin_found, status,
    input  ready
  );
  modport sink (
    input  valid, correction, bin_found, status,
    output ready
  );
endinterface

FILE: hdl/twbl_ram.sv
module twbl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hdl/twbl_row_mem.sv
module twbl_row_mem #(
  parameter int ROWS  = 256,
  parameter int LANES = 32,
  parameter int WIDTH = 16,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [LANES-1:0]            lane_we,
  input  logic [AW-1:0]               addr,
  input  logic [WIDTH-1:0]            wdata,
  output logic [LANES-1:0][WIDTH-1:0] rdata
);

  // one row per channel; a write touches only the enabled lanes
  logic [LANES-1:0][WIDTH-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        for (int l = 0; l < LANES; l++) begin
          if (lane_we[l]) begin
            mem[addr][l] <= wdata;
          end
        end
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hdl/time_walk_bin_lookup_top.sv
// Time-walk correction lookup, one piecewise-constant table per channel.
//
// in_word (sink): op selects write-bin, set-count or query. Write-bin stores one
//   bin's lower energy edge and Q8.8 correction; set-count sets how many bins a
//   channel uses (0 = no table, above MAX_BINS saturates). Neither gives a result.
// out_word (source): one word per query: correction, bin_found, status.
//   status 1 means the channel has no table; correction and bin_found are 0 then.
//
// Sequencing: write-bin and set-count complete when accepted. A query passes
// through the edge-row read, a registered compare of all edges, the bin
// select with the correction read, and the output register load; a query on
// a channel without a table skips the select step. in_word.ready stays low
// from the accept until the output register is loaded.
// A stalled receiver holds the result register; a finished query then waits
// in its last step and in_word.ready stays low until the result is taken.
// Writes and set-count words are still taken while a result waits.
//
// Reset clears the control state and the per-channel table-valid bits, so
// every channel reads as having no table. Edge and correction entries hold
// whatever they had until written.
module time_walk_bin_lookup_top #(
  parameter int NUM_CHANNELS = twbl_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_BINS     = twbl_pkg::MAX_BINS_DEF,
  parameter int ENERGY_BITS  = twbl_pkg::ENERGY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  twbl_in_if.sink       in_word,
  twbl_out_if.source    out_word
);
  import twbl_pkg::*;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int DEPTH  = NUM_CHANNELS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  // edges and energy are compared on their low ENERGY_BITS bits, capped at EDGE_W
  localparam int CMP_W  = (ENERGY_BITS < EDGE_W) ? ENERGY_BITS : EDGE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_OUT
  } state_t;

  state_t state_r;

  // query context
  logic                    ch_ok_r;
  logic                    cnt_vld_q_r;
  logic [CMP_W-1:0]        e_r;
  logic [ADDR_W-1:0]       base_r;
  // compare results
  logic                    lo_le_r;
  logic                    hi_ge_r;
  logic [BIN_W-1:0]        last_r;
  logic [MAX_BINS-1:0]     gt_r;
  logic                    err_r;
  logic [BIN_W-1:0]        sel_r;
  // result register
  logic                    out_valid_r;
  logic signed [CORR_W-1:0] out_corr_r;
  logic [BIN_FOUND_W-1:0]  out_bin_r;
  logic                    out_status_r;

  logic [NUM_CHANNELS-1:0] cnt_vld_r;

  logic                    in_acc;
  logic                    op_wr, op_cnt, op_q;
  logic                    ch_ok, bin_ok;
  logic [CH_W-1:0]         ch_idx;
  logic [BIN_W-1:0]        lane;
  logic [CNT_W-1:0]        cnt_sat;

  logic                    edge_en, edge_we;
  logic [MAX_BINS-1:0]     lane_we;
  logic [MAX_BINS-1:0][CMP_W-1:0] row_q;

  logic                    cnt_en, cnt_we;
  logic [CNT_W-1:0]        cnt_q;

  logic                    corr_en, corr_we;
  logic [ADDR_W-1:0]       corr_addr;
  logic [CORR_W-1:0]       corr_q;

  logic [CNT_W-1:0]        n_bins;
  logic [BIN_W-1:0]        last_c;
  logic                    lo_le_c, hi_ge_c;
  logic [MAX_BINS-1:0]     gt_c;
  logic [BIN_W-1:0]        sel_c;
  logic                    out_free;

  // ---------------------------------------------------------------------------
  // input decode
  // ---------------------------------------------------------------------------
  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc  = in_word.valid && in_word.ready;
  assign op_wr   = (in_word.op == OP_WRITE_BIN);
  assign op_cnt  = (in_word.op == OP_SET_COUNT);
  assign op_q    = (in_word.op == OP_QUERY);
  assign ch_ok   = (32'(in_word.channel) < 32'(NUM_CHANNELS));
  assign bin_ok  = (32'(in_word.bin_index) < 32'(MAX_BINS));
  assign ch_idx  = CH_W'(in_word.channel);
  assign lane    = BIN_W'(in_word.bin_index);
  assign cnt_sat = (32'(in_word.bin_count) > 32'(MAX_BINS)) ? CNT_W'(MAX_BINS)
                                                            : CNT_W'(in_word.bin_count);

  always_comb begin
    lane_we       = '0;
    lane_we[lane] = 1'b1;
  end

  // edge rows: written lane-wise, read whole for a query
  assign edge_we = op_wr;
  assign edge_en = in_acc && ch_ok && ((op_wr && bin_ok) || op_q);

  twbl_row_mem #(
    .ROWS  (NUM_CHANNELS),
    .LANES (MAX_BINS),
    .WIDTH (CMP_W)
  ) u_edge_mem (
    .clk     (clk),
    .en      (edge_en),
    .we      (edge_we),
    .lane_we (lane_we),
    .addr    (ch_idx),
    .wdata   (CMP_W'(in_word.edge_value)),
    .rdata   (row_q)
  );

  // bin counts, qualified by the valid bits below
  assign cnt_we = op_cnt;
  assign cnt_en = in_acc && ch_ok && (op_cnt || op_q);

  twbl_ram #(
    .DEPTH (NUM_CHANNELS),
    .WIDTH (CNT_W)
  ) u_cnt_mem (
    .clk   (clk),
    .en    (cnt_en),
    .we    (cnt_we),
    .addr  (ch_idx),
    .wdata (cnt_sat),
    .rdata (cnt_q)
  );

  // corrections: written from the input word, read once the bin is known
  always_comb begin
    corr_we   = 1'b0;
    corr_en   = 1'b0;
    corr_addr = base_r + ADDR_W'(sel_c);
    if (state_r == ST_IDLE) begin
      corr_we   = 1'b1;
      corr_en   = in_acc && op_wr && ch_ok && bin_ok;
      corr_addr = ADDR_W'(32'(in_word.channel) * 32'(MAX_BINS) + 32'(in_word.bin_index));
    end else if (state_r == ST_SEL) begin
      corr_en   = 1'b1;
    end
  end

  twbl_ram #(
    .DEPTH (DEPTH),
    .WIDTH (CORR_W)
  ) u_corr_mem (
    .clk   (clk),
    .en    (corr_en),
    .we    (corr_we),
    .addr  (corr_addr),
    .wdata (in_word.correction_value),
    .rdata (corr_q)
  );

  // ---------------------------------------------------------------------------
  // search
  // ---------------------------------------------------------------------------
  assign n_bins  = (ch_ok_r && cnt_vld_q_r) ? cnt_q : '0;
  assign last_c  = BIN_W'(n_bins - CNT_W'(1));
  assign lo_le_c = (e_r <= row_q[0]);
  assign hi_ge_c = (e_r >= row_q[last_c]);

  // a bin edge above the energy, among the bins in use past bin 0
  always_comb begin
    gt_c = '0;
    for (int j = 1; j < MAX_BINS; j++) begin
      gt_c[j] = (32'(j) < 32'(n_bins)) && (row_q[j] > e_r);
    end
  end

  // clamps first, then the bin just below the first edge above the energy
  always_comb begin
    sel_c = last_r;
    if (lo_le_r) begin
      sel_c = '0;
    end else if (!hi_ge_r) begin
      for (int j = MAX_BINS - 1; j >= 1; j--) begin
        if (gt_r[j]) begin
          sel_c = BIN_W'(j - 1);
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_word.ready;

  // ---------------------------------------------------------------------------
  // sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      // the last step reloads the register itself when it is free
      if (out_word.ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && op_q) begin
            ch_ok_r     <= ch_ok;
            cnt_vld_q_r <= ch_ok ? cnt_vld_r[ch_idx] : 1'b0;
            e_r         <= CMP_W'(in_word.energy);
            base_r      <= ADDR_W'(32'(in_word.channel) * 32'(MAX_BINS));
            state_r     <= ST_CMP;
          end
        end
        ST_CMP: begin
          lo_le_r <= lo_le_c;
          hi_ge_r <= hi_ge_c;
          last_r  <= last_c;
          gt_r    <= gt_c;
          if (n_bins == '0) begin
            err_r   <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            err_r   <= 1'b0;
            state_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          sel_r   <= sel_c;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_corr_r   <= err_r ? '0 : corr_q;
            out_bin_r    <= err_r ? '0 : BIN_FOUND_W'(sel_r);
            out_status_r <= err_r ? STATUS_NO_TABLE : STATUS_OK;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // table-valid bit per channel, set by the first set-count write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (in_acc && op_cnt && ch_ok) begin
      cnt_vld_r[ch_idx] <= 1'b1;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.correction = out_corr_r;
  assign out_word.bin_found  = out_bin_r;
  assign out_word.status     = out_status_r;

endmodule

FILE: hdl/twbl_checker.sv
module twbl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [twbl_pkg::OP_W-1:0]         in_op,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [twbl_pkg::CORR_W-1:0] out_correction,
  input logic [twbl_pkg::BIN_FOUND_W-1:0]  out_bin_found,
  input logic                              out_status
);
  import twbl_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_correction) &&
                                $stable(out_bin_found) && $stable(out_status))
    else $error("result word changed while stalled");

  // no-table result carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NO_TABLE) |-> (out_correction == '0) &&
                                                     (out_bin_found == '0))
    else $error("no-table result with nonzero fields");

  // writes and set-count words never produce a result right behind them
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_QUERY) |=> !$rose(out_valid))
    else $error("result raised after a non-query word");

  // a query keeps the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_QUERY) |=> !in_ready)
    else $error("input taken during a query");

endmodule

bind time_walk_bin_lookup_top twbl_checker u_twbl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_word.valid),
  .in_ready       (in_word.ready),
  .in_op          (in_word.op),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .out_correction (out_word.correction),
  .out_bin_found  (out_word.bin_found),
  .out_status     (out_word.status)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the per-channel time-walk correction lookup.
// A shadow copy of every channel's edges, corrections and bin count follows
// each accepted word; queries append the predicted result word to a queue
// that the result monitor pops in order.
module tb_top;
  import twbl_pkg::*;

  localparam int NUM_CH      = NUM_CHANNELS_DEF;
  localparam int NUM_BINS    = MAX_BINS_DEF;
  localparam int IDLE_PCT    = 13;
  localparam int END_WORDS   = 1950;
  localparam int HOLD_CYCLES = 150;

  // op code 3 has no meaning; the block must drop it without a trace
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [CHANNEL_W-1:0]     channel;
    logic [BIN_INDEX_W-1:0]   bin_index;
    logic [BIN_COUNT_W-1:0]   bin_count;
    logic [EDGE_W-1:0]        edge_value;
    logic signed [CORR_W-1:0] correction_value;
    logic [ENERGY_W-1:0]      energy;
  } lut_word_t;

  typedef struct {
    logic signed [CORR_W-1:0] correction;
    logic [BIN_FOUND_W-1:0]   bin_found;
    logic                     status;
  } lut_result_t;

  logic clk;
  logic rst_n;

  twbl_in_if  in_word ();
  twbl_out_if out_word ();

  time_walk_bin_lookup_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // shadow of the lookup tables
  logic [EDGE_W-1:0]        edge_shadow [NUM_CH][NUM_BINS];
  logic signed [CORR_W-1:0] corr_shadow [NUM_CH][NUM_BINS];
  int unsigned              count_shadow [NUM_CH];
  logic [NUM_BINS-1:0]      written_bins [NUM_CH];

  lut_result_t pending_corrections [$];

  int          errors     = 0;
  int unsigned words_sent = 0;
  bit          quiet      = 1'b0;   // no idling on either side while set
  int          hold_reqs  = 0;      // bumped to ask the receiver for one hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Clamp checks first, then a linear walk up while the next edge fits.
  // Works for edges that fall or repeat too.
  function automatic int unsigned select_bin(int unsigned ch, logic [ENERGY_W-1:0] e);
    int unsigned n;
    int unsigned i;
    n = count_shadow[ch];
    i = 0;
    if (e <= edge_shadow[ch][0]) return 0;
    if (e >= edge_shadow[ch][n-1]) return n - 1;
    while (i + 1 < n && edge_shadow[ch][i+1] <= e) i++;
    return i;
  endfunction

  function automatic void track_word(lut_word_t w);
    lut_result_t r;
    int unsigned sel;
    case (w.op)
      OP_WRITE_BIN: begin
        edge_shadow[w.channel][w.bin_index]  = w.edge_value;
        corr_shadow[w.channel][w.bin_index]  = w.correction_value;
        written_bins[w.channel][w.bin_index] = 1'b1;
      end
      OP_SET_COUNT: begin
        count_shadow[w.channel] = (w.bin_count > NUM_BINS) ? NUM_BINS : w.bin_count;
      end
      OP_QUERY: begin
        if (count_shadow[w.channel] == 0) begin
          r.correction = '0;
          r.bin_found  = '0;
          r.status     = STATUS_NO_TABLE;
        end else begin
          sel          = select_bin(w.channel, w.energy);
          r.correction = corr_shadow[w.channel][sel];
          r.bin_found  = sel[BIN_FOUND_W-1:0];
          r.status     = STATUS_OK;
        end
        pending_corrections.insert(pending_corrections.size(), r);
      end
      default: ;
    endcase
  endfunction

  // A query may only touch bins that were written: either no table at all,
  // or every bin below the count holds data.
  function automatic bit table_ready(int unsigned ch);
    for (int unsigned i = 0; i < count_shadow[ch]; i++)
      if (!written_bins[ch][i]) return 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    lut_result_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_corrections.size() == 0) begin
        $error("unexpected result word: correction %0d bin_found %0d status %0d",
               out_word.correction, out_word.bin_found, out_word.status);
        errors++;
      end else begin
        want = pending_corrections.pop_front();
        if (out_word.correction !== want.correction) begin
          $error("correction: expected %0d, got %0d", want.correction, out_word.correction);
          errors++;
        end
        if (out_word.bin_found !== want.bin_found) begin
          $error("bin_found: expected %0d, got %0d", want.bin_found, out_word.bin_found);
          errors++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen      = 0;
    hold_left      = 0;
    out_word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_word.ready <= 1'b0;
        hold_left--;
      end else begin
        out_word.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Every field random; each op then overrides only what it uses, so the
  // fields it should ignore still toggle.
  function automatic lut_word_t random_word();
    lut_word_t w;
    w.op               = OP_W'($urandom_range(3));
    w.channel          = CHANNEL_W'($urandom_range(NUM_CH - 1));
    w.bin_index        = BIN_INDEX_W'($urandom_range(NUM_BINS - 1));
    w.bin_count        = BIN_COUNT_W'($urandom_range(63));
    w.edge_value       = EDGE_W'($urandom);
    w.correction_value = CORR_W'($urandom);
    w.energy           = ENERGY_W'($urandom);
    return w;
  endfunction

  // Drive at negedge, wait for the handshake at posedge. valid stays high
  // on return; the next call lowers it or drives the next word, a drain lowers it.
  task automatic send_word(lut_word_t w);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_word.valid <= 1'b0;
      @(negedge clk);
    end
    in_word.valid            <= 1'b1;
    in_word.op               <= w.op;
    in_word.channel          <= w.channel;
    in_word.bin_index        <= w.bin_index;
    in_word.bin_count        <= w.bin_count;
    in_word.edge_value       <= w.edge_value;
    in_word.correction_value <= w.correction_value;
    in_word.energy           <= w.energy;
    do @(posedge clk); while (!in_word.ready);
    track_word(w);
    if (w.op != OP_UNUSED) words_sent++;
  endtask

  task automatic write_bin(int unsigned ch, int unsigned bin, logic [EDGE_W-1:0] edge_v,
                           logic signed [CORR_W-1:0] corr);
    lut_word_t w;
    w                  = random_word();
    w.op               = OP_WRITE_BIN;
    w.channel          = CHANNEL_W'(ch);
    w.bin_index        = BIN_INDEX_W'(bin);
    w.edge_value       = edge_v;
    w.correction_value = corr;
    send_word(w);
  endtask

  task automatic set_count(int unsigned ch, int unsigned cnt);
    lut_word_t w;
    w           = random_word();
    w.op        = OP_SET_COUNT;
    w.channel   = CHANNEL_W'(ch);
    w.bin_count = BIN_COUNT_W'(cnt);
    send_word(w);
  endtask

  task automatic query(int unsigned ch, logic [ENERGY_W-1:0] e);
    lut_word_t w;
    w         = random_word();
    w.op      = OP_QUERY;
    w.channel = CHANNEL_W'(ch);
    w.energy  = e;
    send_word(w);
  endtask

  // Sender stops and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_word.valid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  // Energies that sit on, just below and just above stored edges, plus the
  // ends of the range and random values.
  function automatic logic [ENERGY_W-1:0] pick_energy(int unsigned ch);
    logic [EDGE_W-1:0] e;
    e = edge_shadow[ch][$urandom_range(count_shadow[ch] - 1)];
    case ($urandom_range(5))
      0:       return ENERGY_W'($urandom);
      1:       return e;
      2:       return e - 16'd1;
      3:       return e + 16'd1;
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // Fill bins 0..n-1 of a random channel in shuffled order, set the count,
  // then ask a handful of questions. Edges mostly rise; some tables repeat
  // edges, a few are left unsorted.
  task automatic build_table_and_query();
    int unsigned       ch;
    int unsigned       n;
    int unsigned       kind;
    int unsigned       cnt;
    logic [EDGE_W-1:0] edges [$];
    int unsigned       order [$];
    ch   = $urandom_range(NUM_CH - 1);
    n    = ($urandom_range(9) == 0) ? NUM_BINS : $urandom_range(1, 8);
    kind = $urandom_range(9);
    for (int unsigned i = 0; i < n; i++) begin
      if (kind < 6 || kind == 9) edges.insert(edges.size(), EDGE_W'($urandom));
      else edges.insert(edges.size(), EDGE_W'(32'h1000 * $urandom_range(1, 3)));
      order.insert(order.size(), i);
    end
    if (kind < 9) edges.sort();
    order.shuffle();
    foreach (order[j]) write_bin(ch, order[j], edges[order[j]], CORR_W'($urandom));
    // full tables sometimes get an oversized count, which must saturate
    cnt = (n == NUM_BINS && $urandom_range(1)) ? $urandom_range(NUM_BINS, 63) : n;
    set_count(ch, cnt);
    repeat ($urandom_range(2, 10)) query(ch, pick_energy(ch));
  endtask

  // One slice of random traffic: mostly well-formed tables, the rest noise.
  task automatic traffic_step();
    int unsigned roll;
    int unsigned ch;
    lut_word_t   w;
    roll = $urandom_range(99);
    ch   = $urandom_range(NUM_CH - 1);
    if (roll < 55) begin
      build_table_and_query();
    end else if (roll < 72) begin
      // revisit an old channel; empty ones must answer no-table
      if (count_shadow[ch] == 0) query(ch, ENERGY_W'($urandom));
      else if (table_ready(ch)) repeat ($urandom_range(1, 4)) query(ch, pick_energy(ch));
    end else if (roll < 79) begin
      w    = random_word();
      w.op = OP_UNUSED;
      send_word(w);
    end else if (roll < 89) begin
      write_bin(ch, $urandom_range(NUM_BINS - 1), EDGE_W'($urandom), CORR_W'($urandom));
    end else if (roll < 97) begin
      set_count(ch, $urandom_range(63));
    end else begin
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // after reset no channel has a table
  task automatic test_no_table();
    query(0, 16'h1234);
  endtask

  task automatic test_ignored_op();
    lut_word_t w;
    w    = random_word();
    w.op = OP_UNUSED;
    send_word(w);
  endtask

  // edges at the ends of the range; both clamps and the middle
  task automatic test_clamps();
    write_bin(255, 0, 16'h0000, -16'sd32768);
    write_bin(255, 1, 16'hFFFF, 16'sd32767);
    set_count(255, 2);
    query(255, 16'h0000);
    query(255, 16'hFFFF);
    query(255, 16'h8000);
  endtask

  // oversized count saturates, then count zero takes the table away
  task automatic test_count_zero();
    set_count(7, 40);
    set_count(7, 0);
    query(7, 16'h0100);
  endtask

  // falling middle edge: walk must stop where the successor is above
  task automatic test_non_rising_edges();
    write_bin(1, 0, 16'd100, 16'sd256);
    write_bin(1, 1, 16'd50, -16'sd128);
    write_bin(1, 2, 16'd300, 16'sd77);
    set_count(1, 3);
    query(1, 16'd200);
    query(1, 16'd60);
  endtask

  // one bin: both clamps land on bin 0
  task automatic test_single_bin();
    write_bin(2, 0, 16'd500, -16'sd5);
    set_count(2, 1);
    query(2, 16'd10);
    query(2, 16'd600);
  endtask

  task automatic test_random_traffic(int unsigned upto);
    while (words_sent < upto) traffic_step();
  endtask

  // no idling on either side for a while
  task automatic test_streaming(int unsigned words);
    int unsigned stop_at;
    stop_at = words_sent + words;
    quiet   = 1'b1;
    while (words_sent < stop_at) traffic_step();
    quiet = 1'b0;
  endtask

  // Receiver holds off while queries and writes keep coming; the result
  // register fills and the input has to stall on the next query.
  task automatic test_backpressure();
    for (int unsigned i = 0; i < 4; i++)
      write_bin(3, i, EDGE_W'(32'h2000 * (i + 1)), CORR_W'($urandom));
    set_count(3, 4);
    wait_drained();
    hold_reqs++;
    repeat (24) begin
      if ($urandom_range(1)) query(3, pick_energy(3));
      else write_bin(3, $urandom_range(4, NUM_BINS - 1), EDGE_W'($urandom),
                     CORR_W'($urandom));
    end
  endtask

  // queries, full stop until all answered, then straight on
  task automatic test_drain_pause();
    repeat (5) query(3, pick_energy(3));
    wait_drained();
    query(3, pick_energy(3));
    if (table_ready(0)) query(0, 16'hFFFF);
  endtask

  initial begin
    rst_n                    = 1'b0;
    in_word.valid            = 1'b0;
    in_word.op               = OP_WRITE_BIN;
    in_word.channel          = '0;
    in_word.bin_index        = '0;
    in_word.bin_count        = '0;
    in_word.edge_value       = '0;
    in_word.correction_value = '0;
    in_word.energy           = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      count_shadow[i] = 0;
      written_bins[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_table();
    test_ignored_op();
    test_clamps();
    test_count_zero();
    test_non_rising_edges();
    test_single_bin();
    test_random_traffic(900);
    test_streaming(300);
    test_backpressure();
    test_drain_pause();
    test_random_traffic(END_WORDS);

    // let the last queries be answered; leave some slack
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
